### rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies; users must provide clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bqm_pkg.sv
// shared constants and types for the multichannel tdf2 biquad
// no dependencies
package bqm_pkg;

	localparam int CHANNELS = 2;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 32;
	localparam int ST_W     = 48;
	localparam int MOP_W    = 25;
	localparam int PROD_W   = COEF_W + MOP_W;
	localparam int ACC_W    = 56;
	localparam int CFG_IW   = 3;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IW-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IW-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IW-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IW-1:0] REG_A2 = 3'd4;

	// unity gain in q4.27
	localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd134217728;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coefs_t;

	typedef enum logic [2:0] {
		MUL_B0X,
		MUL_B1X,
		MUL_B2X,
		MUL_A1L,
		MUL_A1H,
		MUL_A2L,
		MUL_A2H
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t sel;
		logic     ld_state;
		logic     ld_y;
		logic     init_acc1;
		logic     init_acc2;
		logic     ld_t;
		logic     ld_m;
		logic     sub_acc1;
		logic     sub_acc2;
	} dp_ctrl_t;

endpackage

### rtl/bqm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module bqm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/bqm_coef_regs.sv
// coefficient register file, written through the configuration port
// depends on bqm_pkg
module bqm_coef_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bqm_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [bqm_pkg::COEF_W-1:0]    cfg_data,
	output bqm_pkg::coefs_t               coefs
);

	bqm_pkg::coefs_t coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// b0 sits in the top field, unity gain; all others zero
			coefs_q <= {bqm_pkg::B0_RESET, {(4*bqm_pkg::COEF_W){1'b0}}};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bqm_pkg::REG_B0: coefs_q.b0 <= cfg_data;
				bqm_pkg::REG_B1: coefs_q.b1 <= cfg_data;
				bqm_pkg::REG_B2: coefs_q.b2 <= cfg_data;
				bqm_pkg::REG_A1: coefs_q.a1 <= cfg_data;
				bqm_pkg::REG_A2: coefs_q.a2 <= cfg_data;
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

### rtl/bqm_datapath.sv
// shared multiplier and accumulators for one biquad update
// depends on bqm_pkg
module bqm_datapath (
	input  logic                                   clk,
	input  bqm_pkg::dp_ctrl_t                      ctrl,
	input  bqm_pkg::coefs_t                        coefs,
	input  logic signed [bqm_pkg::SAMPLE_W-1:0]    x,
	input  logic [2*bqm_pkg::ST_W-1:0]             rd_data,
	input  logic                                   rd_ok,
	output logic signed [bqm_pkg::ST_W-1:0]        s1_new,
	output logic signed [bqm_pkg::ST_W-1:0]        s2_new,
	output logic signed [bqm_pkg::SAMPLE_W-1:0]    sample_res,
	output logic                                   clip_res
);

	localparam int ST_W   = bqm_pkg::ST_W;
	localparam int ACC_W  = bqm_pkg::ACC_W;
	localparam int PROD_W = bqm_pkg::PROD_W;
	localparam int MOP_W  = bqm_pkg::MOP_W;
	localparam int SW     = bqm_pkg::SAMPLE_W;
	localparam int T_W    = PROD_W - 24;
	localparam int OUT_SH = 17;

	localparam logic signed [PROD_W-1:0] RND_X = 512;
	localparam logic signed [PROD_W-1:0] RND_L = 67108864;
	localparam logic signed [ST_W:0]     RND_O = 65536;
	localparam logic signed [ST_W-1:0]   ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
	localparam logic signed [ST_W-1:0]   ST_MIN = {1'b1, {(ST_W-1){1'b0}}};
	localparam logic signed [SW-1:0]     SMP_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0]     SMP_MIN = {1'b1, {(SW-1){1'b0}}};

	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-ST_W:0] hi;
		hi = v[ACC_W-1:ST_W-1];
		if (hi == '0 || hi == '1) begin
			return v[ST_W-1:0];
		end
		return v[ACC_W-1] ? ST_MIN : ST_MAX;
	endfunction

	logic signed [bqm_pkg::COEF_W-1:0] mul_a;
	logic signed [MOP_W-1:0]           mul_b;
	logic signed [PROD_W-1:0]          prod;

	logic signed [PROD_W-1:0] p_q;
	logic signed [ST_W-1:0]   s1_q, s2_q, y_q;
	logic signed [ACC_W-1:0]  acc1_q, acc2_q;
	logic signed [T_W-1:0]    t_q;
	logic signed [PROD_W-1:0] m_q;

	logic signed [PROD_W-1:0] px_sum, px_full, t_sum, t_full, m_nxt, m_full;
	logic signed [ACC_W-1:0]  px, s1_ext, s2_ext, y_sum, m_sh;
	logic signed [T_W-1:0]    t_nxt;
	logic signed [ST_W:0]     o_sum;
	logic [ST_W-OUT_SH-SW+1:0] o_hi;

	// operand select for the one shared multiplier
	always_comb begin
		mul_a = coefs.b0;
		mul_b = {x[SW-1], x};
		case (ctrl.sel)
			bqm_pkg::MUL_B0X: begin
				mul_a = coefs.b0;
				mul_b = {x[SW-1], x};
			end
			bqm_pkg::MUL_B1X: begin
				mul_a = coefs.b1;
				mul_b = {x[SW-1], x};
			end
			bqm_pkg::MUL_B2X: begin
				mul_a = coefs.b2;
				mul_b = {x[SW-1], x};
			end
			bqm_pkg::MUL_A1L: begin
				mul_a = coefs.a1;
				mul_b = {1'b0, y_q[23:0]};
			end
			bqm_pkg::MUL_A1H: begin
				mul_a = coefs.a1;
				mul_b = {y_q[ST_W-1], y_q[ST_W-1:24]};
			end
			bqm_pkg::MUL_A2L: begin
				mul_a = coefs.a2;
				mul_b = {1'b0, y_q[23:0]};
			end
			bqm_pkg::MUL_A2H: begin
				mul_a = coefs.a2;
				mul_b = {y_q[ST_W-1], y_q[ST_W-1:24]};
			end
			default: begin
				mul_a = coefs.b0;
				mul_b = {x[SW-1], x};
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// x*coef rounded to q8.40
	assign px_sum  = p_q + RND_X;
	assign px_full = px_sum >>> 10;
	assign px      = $signed(px_full[ACC_W-1:0]);

	assign s1_ext = $signed({{(ACC_W-ST_W){s1_q[ST_W-1]}}, s1_q});
	assign s2_ext = $signed({{(ACC_W-ST_W){s2_q[ST_W-1]}}, s2_q});
	assign y_sum  = px + s1_ext;

	// low half of y*coef, rounded and moved down 24 bits
	assign t_sum  = p_q + RND_L;
	assign t_full = t_sum >>> 24;
	assign t_nxt  = $signed(t_full[T_W-1:0]);

	// high half plus carried low half, then down 3 more bits
	assign m_nxt  = p_q + $signed({{(PROD_W-T_W){t_q[T_W-1]}}, t_q});
	assign m_full = m_q >>> 3;
	assign m_sh   = $signed(m_full[ACC_W-1:0]);

	always_ff @(posedge clk) begin
		p_q <= prod;
		if (ctrl.ld_state) begin
			s1_q <= rd_ok ? rd_data[2*ST_W-1:ST_W] : '0;
			s2_q <= rd_ok ? rd_data[ST_W-1:0] : '0;
		end
		if (ctrl.ld_y) begin
			y_q <= sat_st(y_sum);
		end
		if (ctrl.init_acc1) begin
			acc1_q <= px + s2_ext;
		end else if (ctrl.sub_acc1) begin
			acc1_q <= acc1_q - m_sh;
		end
		if (ctrl.init_acc2) begin
			acc2_q <= px;
		end else if (ctrl.sub_acc2) begin
			acc2_q <= acc2_q - m_sh;
		end
		if (ctrl.ld_t) begin
			t_q <= t_nxt;
		end
		if (ctrl.ld_m) begin
			m_q <= m_nxt;
		end
	end

	assign s1_new = sat_st(acc1_q);
	assign s2_new = sat_st(acc2_q);

	// round y to q1.23 and clamp
	assign o_sum = $signed({y_q[ST_W-1], y_q}) + RND_O;
	assign o_hi  = o_sum[ST_W:OUT_SH+SW-1];

	always_comb begin
		if (o_hi == '0 || o_hi == '1) begin
			sample_res = $signed(o_sum[OUT_SH+SW-1:OUT_SH]);
			clip_res   = 1'b0;
		end else begin
			sample_res = o_sum[ST_W] ? SMP_MIN : SMP_MAX;
			clip_res   = 1'b1;
		end
	end

endmodule

### rtl/biquad_tdf2_multichannel_top.sv
// multichannel tdf2 biquad top level; depends on bqm_pkg, bqm_ram, bqm_coef_regs,
// bqm_datapath and assert_macros.svh
// a taken word steps through b0x to sub2 and write-back, then is registered onto the output
// input words are taken only while idle, so each must wait until the one before is written back;
// the single 32x25 multiplier runs the seven partial products in turn, then the state is written back
// reset: coefs go to b0 = 1.0 and zeros; per-channel valid flags make the delay state read as zero
`include "assert_macros.svh"

module biquad_tdf2_multichannel_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_wr_en,
	input  logic [bqm_pkg::CFG_IW-1:0]            cfg_index,
	input  logic [bqm_pkg::COEF_W-1:0]            cfg_data,
	// input words
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  chan,
	input  logic signed [bqm_pkg::SAMPLE_W-1:0]   sample_in,
	// output words
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  chan_out,
	output logic signed [bqm_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                  clipped
);

	localparam int ST_W  = bqm_pkg::ST_W;
	localparam int CH_AW = bqm_pkg::CH_AW;

	// idle, one state per product of the shared multiplier named after the product it starts, then m2, sub2, write-back
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B0X,
		ST_B1X,
		ST_B2X,
		ST_A1L,
		ST_A1H,
		ST_A2L,
		ST_A2H,
		ST_M2,
		ST_SUB2,
		ST_WB
	} state_t;

	state_t state_q;

	logic                                 chan_q;
	logic signed [bqm_pkg::SAMPLE_W-1:0]  x_q;
	logic [bqm_pkg::CHANNELS-1:0]         ent_ok_q;

	logic                                 out_valid_q;
	logic                                 chan_out_q;
	logic signed [bqm_pkg::SAMPLE_W-1:0]  sample_out_q;
	logic                                 clipped_q;

	bqm_pkg::coefs_t   coefs;
	bqm_pkg::dp_ctrl_t ctrl;

	logic                          in_take;
	logic                          wb_go;
	logic                          chan_ok;
	logic [CH_AW-1:0]              ch_addr;
	logic                          ram_we;
	logic [2*ST_W-1:0]             ram_rdata;
	logic signed [ST_W-1:0]        s1_new, s2_new;
	logic signed [bqm_pkg::SAMPLE_W-1:0] sample_res;
	logic                          clip_res;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	// channels beyond the configured count give a zero word and leave the state alone
	assign chan_ok = (int'(chan_q) < bqm_pkg::CHANNELS);
	assign ch_addr = CH_AW'(chan_q);

	// write-back waits only while an older word still sits unread in the output register
	assign wb_go  = (state_q == ST_WB) && (!out_valid_q || !out_stall);
	assign ram_we = wb_go && chan_ok;

	bqm_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	// both delay states of a channel live side by side in one entry, s1 in the upper half
	bqm_ram #(
		.WIDTH (2 * ST_W),
		.DEPTH (bqm_pkg::CHANNELS)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ch_addr),
		.wr_data ({s1_new, s2_new}),
		.rd_en   (in_take),
		.rd_addr (CH_AW'(chan)),
		.rd_data (ram_rdata)
	);

	bqm_datapath u_datapath (
		.clk        (clk),
		.ctrl       (ctrl),
		.coefs      (coefs),
		.x          (x_q),
		.rd_data    (ram_rdata),
		.rd_ok      (ent_ok_q[ch_addr]),
		.s1_new     (s1_new),
		.s2_new     (s2_new),
		.sample_res (sample_res),
		.clip_res   (clip_res)
	);

	// step decode: each product step issues one product; from b1x through m2 each step consumes the one before it
	always_comb begin
		ctrl     = '0;
		ctrl.sel = bqm_pkg::MUL_B0X;
		unique case (state_q)
			ST_B0X: begin
				ctrl.sel      = bqm_pkg::MUL_B0X;
				ctrl.ld_state = 1'b1; // ram data arrives this cycle
			end
			ST_B1X: begin
				ctrl.sel  = bqm_pkg::MUL_B1X;
				ctrl.ld_y = 1'b1;
			end
			ST_B2X: begin
				ctrl.sel       = bqm_pkg::MUL_B2X;
				ctrl.init_acc1 = 1'b1;
			end
			ST_A1L: begin
				ctrl.sel       = bqm_pkg::MUL_A1L;
				ctrl.init_acc2 = 1'b1;
			end
			ST_A1H: begin
				ctrl.sel  = bqm_pkg::MUL_A1H;
				ctrl.ld_t = 1'b1;
			end
			ST_A2L: begin
				ctrl.sel  = bqm_pkg::MUL_A2L;
				ctrl.ld_m = 1'b1;
			end
			ST_A2H: begin
				ctrl.sel      = bqm_pkg::MUL_A2H;
				ctrl.sub_acc1 = 1'b1;
				ctrl.ld_t     = 1'b1;
			end
			ST_M2: begin
				ctrl.ld_m = 1'b1;
			end
			ST_SUB2: begin
				ctrl.sub_acc2 = 1'b1;
			end
			default: ; // idle and write-back drive no datapath step
		endcase
	end

	// sequencer, entry valid flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			chan_q       <= 1'b0;
			x_q          <= '0;
			ent_ok_q     <= '0;
			out_valid_q  <= 1'b0;
			chan_out_q   <= 1'b0;
			sample_out_q <= '0;
			clipped_q    <= 1'b0;
		end else begin
			// a word taken while the next one is written back is replaced below
			if (out_valid_q && !out_stall && !wb_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						chan_q  <= chan;
						x_q     <= sample_in;
						state_q <= ST_B0X;
					end
				end
				ST_B0X:  state_q <= ST_B1X;
				ST_B1X:  state_q <= ST_B2X;
				ST_B2X:  state_q <= ST_A1L;
				ST_A1L:  state_q <= ST_A1H;
				ST_A1H:  state_q <= ST_A2L;
				ST_A2L:  state_q <= ST_A2H;
				ST_A2H:  state_q <= ST_M2;
				ST_M2:   state_q <= ST_SUB2;
				ST_SUB2: state_q <= ST_WB;
				ST_WB: begin
					if (wb_go) begin
						out_valid_q  <= 1'b1;
						chan_out_q   <= chan_q;
						sample_out_q <= chan_ok ? sample_res : '0;
						clipped_q    <= chan_ok && clip_res;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ram_we) begin
				ent_ok_q[ch_addr] <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign chan_out   = chan_out_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	// checks on the sequencer
	`ASSERT_CLK(a_take_starts_run, in_take |=> (state_q == ST_B0X), "accepted word did not start a run")
	`ASSERT_CLK(a_wr_only_in_wb, ram_we |-> (state_q == ST_WB), "state written outside write-back")
	`ASSERT_CLK(a_word_after_wb, $rose(out_valid_q) |-> ($past(state_q) == ST_WB), "output word not from write-back")
	`ASSERT_RST(a_wb_entry, (state_q == ST_WB) |-> ($past(state_q) == ST_SUB2 || $past(state_q) == ST_WB), "write-back entered early")

endmodule
